@@ rtl/dlr_pkg.sv @@
// ----------------------------------------------------------------------------
// dlr_pkg: shared types and constants for the DDA line rasterizer
// Holds the controller states, the command and status bundles between the
// controller and the datapath, and the fixed field widths and codes.
// ----------------------------------------------------------------------------
package dlr_pkg;

    // Default fixed-point and coordinate widths
    localparam int FRAC_BITS_DEF  = 16;
    localparam int COORD_BITS_DEF = 12;

    // Fixed field widths
    localparam int CFG_W       = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int ADDR_W      = 20;
    localparam int COLOR_W     = 32;

    // Configuration register indexes and reset values
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]       CANVAS_WIDTH_RESET  = 11'd800;
    localparam logic [CFG_W-1:0]       CANVAS_HEIGHT_RESET = 11'd600;

    // Action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } dlr_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic div_step;
        logic out_load;
    } dlr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic zero_len;
        logic div_last;
        logic out_free;
    } dlr_status_t;

endpackage

@@ rtl/dlr_ctrl.sv @@
// ----------------------------------------------------------------------------
// dlr_ctrl: sequencer of the DDA line rasterizer
// Takes one transaction at a time, runs the increment divide for a start of
// nonzero length and hands the result to the output register once it is free.
// ----------------------------------------------------------------------------
module dlr_ctrl
    import dlr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  dlr_status_t status,
    output dlr_cmd_t    cmd
);

    dlr_state_t state_reg;
    dlr_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.div_step = 1'b0;
        cmd.out_load = 1'b0;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (action == ACT_START && !status.zero_len)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/dlr_datapath.sv @@
// ----------------------------------------------------------------------------
// dlr_datapath: line state, increment divider and pixel output stage
// Holds the canvas registers, the fixed-point position and increments, two
// restoring dividers that run side by side, and the output register.
// ----------------------------------------------------------------------------
module dlr_datapath
    import dlr_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dlr_cmd_t                      cmd,
    output dlr_status_t                   status,
    input  logic                          action,
    input  logic signed [COORD_BITS-1:0]  start_x,
    input  logic signed [COORD_BITS-1:0]  start_y,
    input  logic signed [COORD_BITS-1:0]  end_x,
    input  logic signed [COORD_BITS-1:0]  end_y,
    input  logic [COLOR_W-1:0]            line_color,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ADDR_W-1:0]             pixel_address,
    output logic [COLOR_W-1:0]            pixel_color,
    output logic                          write_enable,
    output logic                          line_done
);

    localparam int POS_BITS  = COORD_BITS + 1 + FRAC_BITS;
    localparam int STEP_BITS = FRAC_BITS + 2;
    localparam int QUO_W     = FRAC_BITS + 1;
    localparam int NUM_W     = COORD_BITS + FRAC_BITS + 1;
    localparam int PIX_W     = COORD_BITS + 2;
    localparam int CNT_W     = $clog2(FRAC_BITS + 1);
    localparam int PROD_W    = 2 * CFG_W;

    // Configuration
    logic [CFG_W-1:0] canvas_width_reg;
    logic [CFG_W-1:0] canvas_height_reg;

    // Line state
    logic signed [POS_BITS-1:0] pos_x_reg, pos_y_reg;
    logic [QUO_W-1:0]           quo_x_reg, quo_y_reg;
    logic                       neg_x_reg, neg_y_reg;
    logic [COORD_BITS-1:0]      steps_left_reg;
    logic [COLOR_W-1:0]         held_color_reg;
    logic [CNT_W-1:0]           div_cnt_reg;
    logic                       out_valid_reg;

    // Divider working registers
    logic [COORD_BITS-1:0]      n_reg;
    logic [COORD_BITS-1:0]      rem_x_reg, rem_y_reg;
    logic [QUO_W-1:0]           low_x_reg, low_y_reg;

    // Pixel stage and output registers
    logic [CFG_W-1:0]           pix_x_reg, pix_y_reg;
    logic                       we_flag_reg, done_flag_reg;
    logic [ADDR_W-1:0]          addr_out_reg;
    logic [COLOR_W-1:0]         color_out_reg;
    logic                       we_out_reg, done_out_reg;

    // Start decode
    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS:0]        dx_abs, dy_abs;
    logic [COORD_BITS-1:0]      mag_x, mag_y, n_new;
    logic [NUM_W-1:0]           num_x, num_y;
    logic [POS_BITS-1:0]        start_pos_x, start_pos_y;

    always_comb
    begin
        dx     = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
        dy     = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
        dx_abs = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
        dy_abs = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
        mag_x  = dx_abs[COORD_BITS-1:0];
        mag_y  = dy_abs[COORD_BITS-1:0];
        n_new  = (mag_x > mag_y) ? mag_x : mag_y;
        // rounded dividend: |d| * 2^F + n/2
        num_x  = {1'b0, mag_x, {FRAC_BITS{1'b0}}} + NUM_W'(n_new >> 1);
        num_y  = {1'b0, mag_y, {FRAC_BITS{1'b0}}} + NUM_W'(n_new >> 1);
        start_pos_x = {start_x[COORD_BITS-1], start_x, {FRAC_BITS{1'b0}}};
        start_pos_y = {start_y[COORD_BITS-1], start_y, {FRAC_BITS{1'b0}}};
    end

    // Divider trial subtract, one quotient bit per lane
    logic [COORD_BITS:0]   trial_x, trial_y, diff_x, diff_y;
    logic                  ge_x, ge_y;
    logic [COORD_BITS-1:0] rem_x_next, rem_y_next;

    always_comb
    begin
        trial_x    = {rem_x_reg, low_x_reg[QUO_W-1]};
        trial_y    = {rem_y_reg, low_y_reg[QUO_W-1]};
        diff_x     = trial_x - {1'b0, n_reg};
        diff_y     = trial_y - {1'b0, n_reg};
        ge_x       = (trial_x >= {1'b0, n_reg});
        ge_y       = (trial_y >= {1'b0, n_reg});
        rem_x_next = ge_x ? diff_x[COORD_BITS-1:0] : trial_x[COORD_BITS-1:0];
        rem_y_next = ge_y ? diff_y[COORD_BITS-1:0] : trial_y[COORD_BITS-1:0];
    end

    // Signed increments from quotient and sign
    logic [STEP_BITS-1:0] step_x, step_y;
    logic [POS_BITS-1:0]  pos_x_adv, pos_y_adv;

    always_comb
    begin
        step_x = neg_x_reg ? (~{1'b0, quo_x_reg} + 1'b1) : {1'b0, quo_x_reg};
        step_y = neg_y_reg ? (~{1'b0, quo_y_reg} + 1'b1) : {1'b0, quo_y_reg};
        pos_x_adv = pos_x_reg + {{(POS_BITS - STEP_BITS){step_x[STEP_BITS-1]}}, step_x};
        pos_y_adv = pos_y_reg + {{(POS_BITS - STEP_BITS){step_y[STEP_BITS-1]}}, step_y};
    end

    // Round position half away from zero and clip
    logic [POS_BITS-1:0] abs_x, abs_y;
    logic [POS_BITS:0]   rnd_x, rnd_y;
    logic [PIX_W-1:0]    q_x, q_y;
    logic                in_canvas;

    always_comb
    begin
        abs_x = pos_x_reg[POS_BITS-1] ? (~pos_x_reg + 1'b1) : pos_x_reg;
        abs_y = pos_y_reg[POS_BITS-1] ? (~pos_y_reg + 1'b1) : pos_y_reg;
        rnd_x = {1'b0, abs_x} + ((POS_BITS + 1)'(1) << (FRAC_BITS - 1));
        rnd_y = {1'b0, abs_y} + ((POS_BITS + 1)'(1) << (FRAC_BITS - 1));
        q_x   = rnd_x[POS_BITS:FRAC_BITS];
        q_y   = rnd_y[POS_BITS:FRAC_BITS];
        in_canvas = (!pos_x_reg[POS_BITS-1] || q_x == '0)
                 && (!pos_y_reg[POS_BITS-1] || q_y == '0)
                 && (q_x < PIX_W'(canvas_width_reg))
                 && (q_y < PIX_W'(canvas_height_reg));
    end

    // Linear address of the held pixel
    logic [PROD_W-1:0] addr_sum;

    always_comb
    begin
        addr_sum = (PROD_W'(canvas_width_reg) * PROD_W'(pix_y_reg)) + PROD_W'(pix_x_reg);
    end

    // Status to the controller
    always_comb
    begin
        status.zero_len = (n_new == '0);
        status.div_last = (div_cnt_reg == CNT_W'(FRAC_BITS));
        status.out_free = !out_valid_reg || out_ready;
    end

    // Control and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= CANVAS_WIDTH_RESET;
            canvas_height_reg <= CANVAS_HEIGHT_RESET;
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
            quo_x_reg         <= '0;
            quo_y_reg         <= '0;
            neg_x_reg         <= 1'b0;
            neg_y_reg         <= 1'b0;
            steps_left_reg    <= '0;
            held_color_reg    <= '0;
            div_cnt_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (cfg_we)
            begin
                if (cfg_index == CFG_IDX_WIDTH)
                begin
                    canvas_width_reg <= cfg_data;
                end
                else
                begin
                    canvas_height_reg <= cfg_data;
                end
            end

            // latch a new line or advance one step
            if (cmd.accept)
            begin
                if (action == ACT_START)
                begin
                    pos_x_reg      <= start_pos_x;
                    pos_y_reg      <= start_pos_y;
                    neg_x_reg      <= dx[COORD_BITS];
                    neg_y_reg      <= dy[COORD_BITS];
                    quo_x_reg      <= '0;
                    quo_y_reg      <= '0;
                    steps_left_reg <= n_new;
                    held_color_reg <= line_color;
                    div_cnt_reg    <= '0;
                end
                else if (steps_left_reg != '0)
                begin
                    pos_x_reg      <= pos_x_adv;
                    pos_y_reg      <= pos_y_adv;
                    steps_left_reg <= steps_left_reg - 1'b1;
                end
            end

            // shift in one quotient bit per lane
            if (cmd.div_step)
            begin
                quo_x_reg   <= {quo_x_reg[QUO_W-2:0], ge_x};
                quo_y_reg   <= {quo_y_reg[QUO_W-2:0], ge_y};
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end

            // output register handshake
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            if (action == ACT_START)
            begin
                n_reg         <= n_new;
                rem_x_reg     <= num_x[NUM_W-1:FRAC_BITS+1];
                rem_y_reg     <= num_y[NUM_W-1:FRAC_BITS+1];
                low_x_reg     <= num_x[FRAC_BITS:0];
                low_y_reg     <= num_y[FRAC_BITS:0];
                we_flag_reg   <= 1'b0;
                done_flag_reg <= (n_new == '0);
            end
            else if (steps_left_reg != '0)
            begin
                pix_x_reg     <= q_x[CFG_W-1:0];
                pix_y_reg     <= q_y[CFG_W-1:0];
                we_flag_reg   <= in_canvas;
                done_flag_reg <= (steps_left_reg == COORD_BITS'(1));
            end
            else
            begin
                we_flag_reg   <= 1'b0;
                done_flag_reg <= 1'b1;
            end
        end

        if (cmd.div_step)
        begin
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
            low_x_reg <= {low_x_reg[QUO_W-2:0], 1'b0};
            low_y_reg <= {low_y_reg[QUO_W-2:0], 1'b0};
        end

        if (cmd.out_load)
        begin
            addr_out_reg  <= we_flag_reg ? addr_sum[ADDR_W-1:0] : '0;
            color_out_reg <= held_color_reg;
            we_out_reg    <= we_flag_reg;
            done_out_reg  <= done_flag_reg;
        end
    end

    // Drive outputs
    assign out_valid     = out_valid_reg;
    assign pixel_address = addr_out_reg;
    assign pixel_color   = color_out_reg;
    assign write_enable  = we_out_reg;
    assign line_done     = done_out_reg;

endmodule

@@ rtl/dda_line_rasterizer_top.sv @@
// ----------------------------------------------------------------------------
// dda_line_rasterizer_top: DDA line rasterizer with clipped pixel writes
// A start transaction loads two endpoints and a color and divides the deltas
// by the step count; each step transaction emits one output, a pixel write unless clipped or past the line end.
//
//   channel | signals                                   | role
//   --------+-------------------------------------------+---------------------
//   in      | in_valid, in_ready, action, start_x,      | start or step
//           | start_y, end_x, end_y, line_color         |
//   out     | out_valid, out_ready, pixel_address,      | one per transaction
//           | pixel_color, write_enable, line_done      |
//   cfg     | cfg_we, cfg_index, cfg_data               | canvas width/height
//
// A step transaction is accepted with rounding and clipping, then the
// width*y+x multiply loads the output register.
// A start transaction runs the restoring dividers, which yield one increment
// bit per cycle for x and y, before it emits; a zero-length start skips them.
// The output register holds a result while out_ready is low; the next
// transaction is accepted meanwhile and waits only at its own emit cycle.
// Reset is asynchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_top
    import dlr_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic signed [COORD_BITS-1:0]  start_x,
    input  logic signed [COORD_BITS-1:0]  start_y,
    input  logic signed [COORD_BITS-1:0]  end_x,
    input  logic signed [COORD_BITS-1:0]  end_y,
    input  logic [COLOR_W-1:0]            line_color,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ADDR_W-1:0]             pixel_address,
    output logic [COLOR_W-1:0]            pixel_color,
    output logic                          write_enable,
    output logic                          line_done,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]              cfg_data
);

    dlr_cmd_t    cmd;
    dlr_status_t status;

    // Sequencer
    dlr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    dlr_datapath #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .action        (action),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .line_color    (line_color),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .write_enable  (write_enable),
        .line_done     (line_done)
    );

    // Never load the output register over a result still waiting
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output register overwritten");

    // No transaction is taken while the divider runs
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !in_ready)
        else $error("transaction accepted during divide");

    // The divide stops after its last bit
    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && status.div_last) |=> !cmd.div_step)
        else $error("divider ran past its last bit");

endmodule
